[rtl/obb_pkg.sv]
package obb_pkg;

   // Axis-selection codes carried in the opcode field.
   typedef enum logic [3:0] {
      OP_FROM_U = 4'd0,
      OP_FROM_V = 4'd1,
      OP_FROM_W = 4'd2,
      OP_UV     = 4'd3,
      OP_VU     = 4'd4,
      OP_UW     = 4'd5,
      OP_WU     = 4'd6,
      OP_VW     = 4'd7,
      OP_WV     = 4'd8
   } opcode_type;

   // Squared length, in Q1.14 units squared, at or below which the x-axis cross is too short.
   localparam logic [32:0] FALLBACK_LIMIT = 33'd26843;
   localparam logic [14:0] ONE_Q14        = 15'd16384;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vec16_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec32_type;

   // Travels alongside each transaction through the whole pipeline.
   typedef struct packed {
      logic [3:0] opcode;
      vec16_type  a;
      vec16_type  b;
      vec16_type  p;
      vec16_type  q;
      logic       deg;
   } sideband_type;

   typedef struct packed {
      vec16_type u;
      vec16_type v;
      vec16_type w;
      logic      deg;
   } result_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] root;
   } sqrt_step_type;

   typedef struct packed {
      logic [31:0] rem;
      logic        qbit;
   } div_step_type;

   // One digit of a restoring square root.
   function automatic sqrt_step_type sqrt_step(input logic [32:0] rem, input logic [31:0] root,
                                               input logic [1:0] pair);
      logic [34:0]   t;
      logic [34:0]   trial;
      sqrt_step_type r;
      t     = {rem, pair};
      trial = {1'b0, root, 2'b01};
      if (t >= trial) begin
         r.rem  = 33'(t - trial);
         r.root = {root[30:0], 1'b1};
      end else begin
         r.rem  = t[32:0];
         r.root = {root[30:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of a restoring division; rem stays below the divisor.
   function automatic div_step_type div_step(input logic [31:0] rem, input logic num_bit,
                                             input logic [31:0] divisor);
      logic [32:0]  t;
      div_step_type r;
      t = {rem, num_bit};
      if (t >= {1'b0, divisor}) begin
         r.rem  = 32'(t - {1'b0, divisor});
         r.qbit = 1'b1;
      end else begin
         r.rem  = t[31:0];
         r.qbit = 1'b0;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
      logic signed [31:0] ae;
      logic signed [31:0] be;
      ae = 32'(a);
      be = 32'(b);
      return 32'(ae * be);
   endfunction

   function automatic logic [30:0] abs31(input logic signed [31:0] c);
      logic [31:0] t;
      t = c[31] ? 32'(-c) : 32'(c);
      return t[30:0];
   endfunction

endpackage

[rtl/orthonormal_basis_builder.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  opcode, first_x..z, second_x..z
// rsp_      out        rsp_valid/rsp_stall  u_x..w_z, degenerate
//
// One transaction enters per cycle while req_stall is low. The pipeline consists of three
// normalisers of 54 stages each (32 square-root and 15 division stages), two 2-stage
// cross-product units and the output register.
// Reset clears the valid bits only. A stalled result moves to a skid register so the
// pipeline advances once more; req_stall is high exactly while that register is full.
module orthonormal_basis_builder import obb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [15:0] req_first_x,
   input  logic signed [15:0] req_first_y,
   input  logic signed [15:0] req_first_z,
   input  logic signed [15:0] req_second_x,
   input  logic signed [15:0] req_second_y,
   input  logic signed [15:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_u_x,
   output logic signed [15:0] rsp_u_y,
   output logic signed [15:0] rsp_u_z,
   output logic signed [15:0] rsp_v_x,
   output logic signed [15:0] rsp_v_y,
   output logic signed [15:0] rsp_v_z,
   output logic signed [15:0] rsp_w_x,
   output logic signed [15:0] rsp_w_y,
   output logic signed [15:0] rsp_w_z,
   output logic               rsp_degenerate
);

   logic         enable;
   vec32_type    n1_in_vec;
   sideband_type n1_in_side;
   logic         n1_valid;
   vec16_type    n1_vec;
   logic         n1_zero;
   sideband_type n1_side;
   sideband_type x1_in_side;
   logic         x1_single;
   vec16_type    x1_x;
   vec16_type    x1_y;
   logic         x1_valid;
   vec32_type    x1_vec;
   sideband_type x1_side;
   logic         n2_valid;
   vec16_type    n2_vec;
   logic         n2_zero;
   sideband_type n2_side;
   sideband_type x2_in_side;
   vec16_type    x2_x;
   vec16_type    x2_y;
   logic         x2_valid;
   vec32_type    x2_vec;
   sideband_type x2_side;
   logic         n3_valid;
   vec16_type    n3_vec;
   logic         n3_zero;
   sideband_type n3_side;
   result_type   res;

   logic         out_valid_ff;
   logic         out_valid_in;
   result_type   out_ff;
   result_type   out_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   result_type   skid_ff;
   result_type   skid_in;
   logic         take;

   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      n1_in_vec.x       = 32'(req_first_x);
      n1_in_vec.y       = 32'(req_first_y);
      n1_in_vec.z       = 32'(req_first_z);
      n1_in_side.opcode = req_opcode;
      n1_in_side.a.x    = req_first_x;
      n1_in_side.a.y    = req_first_y;
      n1_in_side.a.z    = req_first_z;
      n1_in_side.b.x    = req_second_x;
      n1_in_side.b.y    = req_second_y;
      n1_in_side.b.z    = req_second_z;
      n1_in_side.p      = '0;
      n1_in_side.q      = '0;
      n1_in_side.deg    = 1'b0;
   end

   obb_norm u_norm1 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_valid),
      .in_vec   (n1_in_vec),
      .in_side  (n1_in_side),
      .out_valid(n1_valid),
      .out_vec  (n1_vec),
      .out_zero (n1_zero),
      .out_side (n1_side)
   );

   // Single-axis modes cross the unit axis; pair modes cross the raw vectors in an order set by the mode.
   always_comb begin
      x1_in_side     = n1_side;
      x1_in_side.p   = n1_vec;
      x1_in_side.deg = n1_zero;
      x1_single      = (n1_side.opcode == OP_FROM_U) || (n1_side.opcode == OP_FROM_V) ||
                       (n1_side.opcode == OP_FROM_W);
      if (x1_single) begin
         x1_x = n1_vec;
         x1_y = n1_side.b;
      end else if ((n1_side.opcode == OP_VU) || (n1_side.opcode == OP_UW) ||
                   (n1_side.opcode == OP_WV)) begin
         x1_x = n1_side.b;
         x1_y = n1_side.a;
      end else begin
         x1_x = n1_side.a;
         x1_y = n1_side.b;
      end
   end

   obb_cross u_cross1 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (n1_valid),
      .in_single(x1_single),
      .in_x     (x1_x),
      .in_y     (x1_y),
      .in_side  (x1_in_side),
      .out_valid(x1_valid),
      .out_vec  (x1_vec),
      .out_side (x1_side)
   );

   obb_norm u_norm2 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (x1_valid),
      .in_vec   (x1_vec),
      .in_side  (x1_side),
      .out_valid(n2_valid),
      .out_vec  (n2_vec),
      .out_zero (n2_zero),
      .out_side (n2_side)
   );

   always_comb begin
      x2_in_side     = n2_side;
      x2_in_side.q   = n2_vec;
      x2_in_side.deg = n2_side.deg | n2_zero;
      if ((n2_side.opcode == OP_UV) || (n2_side.opcode == OP_WU) ||
          (n2_side.opcode == OP_VW)) begin
         x2_x = n2_vec;
         x2_y = n2_side.p;
      end else begin
         x2_x = n2_side.p;
         x2_y = n2_vec;
      end
   end

   obb_cross u_cross2 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (n2_valid),
      .in_single(1'b0),
      .in_x     (x2_x),
      .in_y     (x2_y),
      .in_side  (x2_in_side),
      .out_valid(x2_valid),
      .out_vec  (x2_vec),
      .out_side (x2_side)
   );

   obb_norm u_norm3 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (x2_valid),
      .in_vec   (x2_vec),
      .in_side  (x2_side),
      .out_valid(n3_valid),
      .out_vec  (n3_vec),
      .out_zero (n3_zero),
      .out_side (n3_side)
   );

   // p is the first unit axis, q the second, n3_vec the third; the mode places them.
   always_comb begin
      res.deg = n3_side.deg | n3_zero;
      res.u   = '0;
      res.v   = '0;
      res.w   = '0;
      unique case (n3_side.opcode)
         OP_FROM_U: begin
            res.u = n3_side.p; res.v = n3_side.q; res.w = n3_vec;
         end
         OP_FROM_V: begin
            res.v = n3_side.p; res.w = n3_side.q; res.u = n3_vec;
         end
         OP_FROM_W: begin
            res.w = n3_side.p; res.u = n3_side.q; res.v = n3_vec;
         end
         OP_UV: begin
            res.u = n3_side.p; res.w = n3_side.q; res.v = n3_vec;
         end
         OP_VU: begin
            res.v = n3_side.p; res.w = n3_side.q; res.u = n3_vec;
         end
         OP_UW: begin
            res.u = n3_side.p; res.v = n3_side.q; res.w = n3_vec;
         end
         OP_WU: begin
            res.w = n3_side.p; res.v = n3_side.q; res.u = n3_vec;
         end
         OP_VW: begin
            res.v = n3_side.p; res.u = n3_side.q; res.w = n3_vec;
         end
         OP_WV: begin
            res.w = n3_side.p; res.u = n3_side.q; res.v = n3_vec;
         end
         default: begin
            res.deg = 1'b1;
         end
      endcase
      if (res.deg) begin
         res.u = '0;
         res.v = '0;
         res.w = '0;
      end
   end

   // Output register with a skid stage behind it.
   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !take) begin
         if (enable && n3_valid) begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = n3_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_u_x        = out_ff.u.x;
   assign rsp_u_y        = out_ff.u.y;
   assign rsp_u_z        = out_ff.u.z;
   assign rsp_v_x        = out_ff.v.x;
   assign rsp_v_y        = out_ff.v.y;
   assign rsp_v_z        = out_ff.v.z;
   assign rsp_w_x        = out_ff.w.x;
   assign rsp_w_y        = out_ff.w.y;
   assign rsp_w_z        = out_ff.w.z;
   assign rsp_degenerate = out_ff.deg;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && !skid_valid_ff && n3_valid) |=> skid_valid_ff)
      else $error("stalled result from pipeline not captured in skid register");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (out_ff.u == '0) && (out_ff.v == '0) && (out_ff.w == '0))
      else $error("degenerate transaction carries a non-zero basis");
`endif

endmodule

[rtl/obb_cross.sv]
module obb_cross import obb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  logic         in_single,
   input  vec16_type    in_x,
   input  vec16_type    in_y,
   input  sideband_type in_side,
   output logic         out_valid,
   output vec32_type    out_vec,
   output sideband_type out_side
);

   logic               pr_valid_ff;
   logic               pr_single_ff;
   vec16_type          pr_x_ff;
   logic signed [31:0] pr_ff [6];
   logic signed [31:0] sq_y_ff;
   logic signed [31:0] sq_z_ff;
   sideband_type       pr_side_ff;

   logic               cr_valid_ff;
   vec32_type          cr_vec_ff;
   vec32_type          cr_vec_in;
   sideband_type       cr_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
         cr_valid_ff <= 1'b0;
      end else if (enable) begin
         pr_valid_ff <= in_valid;
         cr_valid_ff <= pr_valid_ff;
      end
      if (enable) begin
         pr_single_ff <= in_single;
         pr_x_ff      <= in_x;
         pr_ff[0]     <= mul16(in_x.y, in_y.z);
         pr_ff[1]     <= mul16(in_x.z, in_y.y);
         pr_ff[2]     <= mul16(in_x.z, in_y.x);
         pr_ff[3]     <= mul16(in_x.x, in_y.z);
         pr_ff[4]     <= mul16(in_x.x, in_y.y);
         pr_ff[5]     <= mul16(in_x.y, in_y.x);
         sq_y_ff      <= mul16(in_x.y, in_x.y);
         sq_z_ff      <= mul16(in_x.z, in_x.z);
         pr_side_ff   <= in_side;
         cr_vec_ff    <= cr_vec_in;
         cr_side_ff   <= pr_side_ff;
      end
   end

   // A single axis is crossed with x, or with y when that cross is too short.
   always_comb begin
      logic [32:0]        len2;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
      len2 = 33'(sq_y_ff) + 33'(sq_z_ff);
      ex   = 32'(pr_x_ff.x);
      ey   = 32'(pr_x_ff.y);
      ez   = 32'(pr_x_ff.z);
      if (pr_single_ff) begin
         if (len2 > FALLBACK_LIMIT) begin
            cr_vec_in.x = '0;
            cr_vec_in.y = ez;
            cr_vec_in.z = 32'(-ey);
         end else begin
            cr_vec_in.x = 32'(-ez);
            cr_vec_in.y = '0;
            cr_vec_in.z = ex;
         end
      end else begin
         cr_vec_in.x = 32'(33'(pr_ff[0]) - 33'(pr_ff[1]));
         cr_vec_in.y = 32'(33'(pr_ff[2]) - 33'(pr_ff[3]));
         cr_vec_in.z = 32'(33'(pr_ff[4]) - 33'(pr_ff[5]));
      end
   end

   assign out_valid = cr_valid_ff;
   assign out_vec   = cr_vec_ff;
   assign out_side  = cr_side_ff;

endmodule

[rtl/obb_norm.sv]
module obb_norm import obb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  vec32_type    in_vec,
   input  sideband_type in_side,
   output logic         out_valid,
   output vec16_type    out_vec,
   output logic         out_zero,
   output sideband_type out_side
);

   typedef struct packed {
      logic [32:0]      rem;
      logic [31:0]      root;
      logic [63:0]      s;
      logic [2:0][30:0] mag;
      logic [2:0]       neg;
      logic             zero;
      sideband_type     side;
   } sq_type;

   typedef struct packed {
      logic [31:0]      n;
      logic [2:0][31:0] rem;
      logic [2:0][14:0] lo;
      logic [2:0][14:0] quo;
      logic [2:0]       neg;
      logic             zero;
      sideband_type     side;
   } dv_type;

   // Magnitudes.
   logic             a_valid_ff;
   logic [2:0][30:0] a_mag_ff;
   logic [2:0]       a_neg_ff;
   sideband_type     a_side_ff;
   // Largest magnitude.
   logic             b_valid_ff;
   logic [2:0][30:0] b_mag_ff;
   logic [2:0]       b_neg_ff;
   logic [30:0]      b_max_ff;
   logic [30:0]      b_max_in;
   sideband_type     b_side_ff;
   // Scaled so that the largest magnitude has bit 30 set.
   logic             c_valid_ff;
   logic [2:0][30:0] c_mag_ff;
   logic [2:0][30:0] c_mag_in;
   logic [2:0]       c_neg_ff;
   logic             c_zero_ff;
   sideband_type     c_side_ff;
   // Squares.
   logic             d_valid_ff;
   logic [2:0][61:0] d_sq_ff;
   logic [2:0][30:0] d_mag_ff;
   logic [2:0]       d_neg_ff;
   logic             d_zero_ff;
   sideband_type     d_side_ff;

   sq_type           sq_ff       [33];
   logic             sq_valid_ff [33];
   dv_type           dv_ff       [16];
   logic             dv_valid_ff [16];

   logic             o_valid_ff;
   vec16_type        o_vec_ff;
   vec16_type        o_vec_in;
   logic             o_zero_ff;
   sideband_type     o_side_ff;

   always_comb begin
      b_max_in = a_mag_ff[0];
      if (a_mag_ff[1] > b_max_in) begin
         b_max_in = a_mag_ff[1];
      end
      if (a_mag_ff[2] > b_max_in) begin
         b_max_in = a_mag_ff[2];
      end
   end

   always_comb begin
      logic [4:0] sh;
      sh = '0;
      for (int i = 0; i < 31; i++) begin
         if (b_max_ff[i]) begin
            sh = 5'(30 - i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         c_mag_in[i] = 31'(b_mag_ff[i] << sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_valid_ff     <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (enable) begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         d_valid_ff     <= c_valid_ff;
         sq_valid_ff[0] <= d_valid_ff;
      end
      if (enable) begin
         a_mag_ff[0] <= abs31(in_vec.x);
         a_mag_ff[1] <= abs31(in_vec.y);
         a_mag_ff[2] <= abs31(in_vec.z);
         a_neg_ff    <= {in_vec.z[31], in_vec.y[31], in_vec.x[31]};
         a_side_ff   <= in_side;

         b_mag_ff    <= a_mag_ff;
         b_neg_ff    <= a_neg_ff;
         b_max_ff    <= b_max_in;
         b_side_ff   <= a_side_ff;

         c_mag_ff    <= c_mag_in;
         c_neg_ff    <= b_neg_ff;
         c_zero_ff   <= (b_max_ff == '0);
         c_side_ff   <= b_side_ff;

         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= 62'(c_mag_ff[i] * c_mag_ff[i]);
         end
         d_mag_ff    <= c_mag_ff;
         d_neg_ff    <= c_neg_ff;
         d_zero_ff   <= c_zero_ff;
         d_side_ff   <= c_side_ff;

         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
         sq_ff[0].s    <= 64'(d_sq_ff[0]) + 64'(d_sq_ff[1]) + 64'(d_sq_ff[2]);
         sq_ff[0].mag  <= d_mag_ff;
         sq_ff[0].neg  <= d_neg_ff;
         sq_ff[0].zero <= d_zero_ff;
         sq_ff[0].side <= d_side_ff;
      end
   end

   // Square root, one result bit per stage, two radicand bits taken each time.
   for (genvar k = 0; k < 32; k++) begin : g_sqrt
      sqrt_step_type st;
      sq_type        nx;
      always_comb begin
         st      = sqrt_step(sq_ff[k].rem, sq_ff[k].root, sq_ff[k].s[63-2*k -: 2]);
         nx      = sq_ff[k];
         nx.rem  = st.rem;
         nx.root = st.root;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         if (enable) begin
            sq_ff[k+1] <= nx;
         end
      end
   end

   // Numerator is the scaled magnitude times 2^14 plus half the length, for rounding.
   always_ff @(posedge clock) begin
      logic [45:0] num;
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (enable) begin
         dv_valid_ff[0] <= sq_valid_ff[32];
      end
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            num = {1'b0, sq_ff[32].mag[i], 14'd0} + 46'(sq_ff[32].root[31:1]);
            dv_ff[0].rem[i] <= 32'(num[45:15]);
            dv_ff[0].lo[i]  <= num[14:0];
            dv_ff[0].quo[i] <= '0;
         end
         dv_ff[0].n    <= sq_ff[32].root;
         dv_ff[0].neg  <= sq_ff[32].neg;
         dv_ff[0].zero <= sq_ff[32].zero;
         dv_ff[0].side <= sq_ff[32].side;
      end
   end

   // Division, one quotient bit per stage for all three components.
   for (genvar j = 0; j < 15; j++) begin : g_div
      dv_type       nx;
      div_step_type st [3];
      always_comb begin
         nx = dv_ff[j];
         for (int i = 0; i < 3; i++) begin
            st[i]      = div_step(dv_ff[j].rem[i], dv_ff[j].lo[i][14-j], dv_ff[j].n);
            nx.rem[i]  = st[i].rem;
            nx.quo[i]  = {dv_ff[j].quo[i][13:0], st[i].qbit};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (enable) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (enable) begin
            dv_ff[j+1] <= nx;
         end
      end
   end

   always_comb begin
      logic [14:0]        q;
      logic signed [15:0] c [3];
      for (int i = 0; i < 3; i++) begin
         q = dv_ff[15].quo[i];
         if (q > ONE_Q14) begin
            q = ONE_Q14;
         end
         c[i] = dv_ff[15].neg[i] ? 16'(-{1'b0, q}) : 16'({1'b0, q});
      end
      o_vec_in.x = c[0];
      o_vec_in.y = c[1];
      o_vec_in.z = c[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         o_valid_ff <= dv_valid_ff[15];
      end
      if (enable) begin
         o_vec_ff  <= o_vec_in;
         o_zero_ff <= dv_ff[15].zero;
         o_side_ff <= dv_ff[15].side;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_vec   = o_vec_ff;
   assign out_zero  = o_zero_ff;
   assign out_side  = o_side_ff;

endmodule
